// File: sv/fts_pkg.sv
// Shared types and constants of the FCFS tick scheduler.
package fts_pkg;

   localparam int JOB_SLOTS = 16;
   localparam int PTR_W     = $clog2(JOB_SLOTS);
   localparam int FILL_W    = $clog2(JOB_SLOTS + 1);
   localparam int SUM_W     = PTR_W + 1;
   localparam int EXEC_W    = 11;

   localparam logic [1:0] CPU_IDLE      = 2'd0;
   localparam logic [1:0] CPU_BUSY      = 2'd1;
   localparam logic [1:0] CPU_SWITCHING = 2'd2;

   // io_len of zero also marks a job that has already done its I/O
   typedef struct packed {
      logic [7:0] pid;
      logic [9:0] left;
      logic [9:0] io_req;
      logic [9:0] io_len;
   } job_type;

   typedef struct packed {
      job_type    job;
      logic [9:0] countdown;
   } waiter_type;

   typedef struct packed {
      logic accept;
      logic dispatch_rd;
      logic load;
      logic cpu_step;
      logic walk;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic dispatch_ok;
      logic walk_done;
      logic out_free;
   } status_type;

endpackage

// File: sv/fts_ram.sv
// Generic single write port, single read port RAM with registered read data.
module fts_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/fts_ctrl.sv
// Tick sequencer: arrival, dispatch, CPU update, wait list walk, result.
module fts_ctrl
   import fts_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [5:0] {
      S_IDLE     = 6'b000001,
      S_DISPATCH = 6'b000010,
      S_LOAD     = 6'b000100,
      S_CPU      = 6'b001000,
      S_WALK     = 6'b010000,
      S_OUT      = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            if (status.dispatch_ok) begin
               cmd.dispatch_rd = 1'b1;
               state_in        = S_LOAD;
            end else begin
               state_in = S_CPU;
            end
         end
         S_LOAD: begin
            cmd.load = 1'b1;
            state_in = S_CPU;
         end
         S_CPU: begin
            cmd.cpu_step = 1'b1;
            state_in     = S_WALK;
         end
         S_WALK: begin
            cmd.walk = 1'b1;
            if (status.walk_done) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |-> (state_ff == S_IDLE) && !req_stall)
      else $error("item accepted outside idle");

   a_load_after_read: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> $past(cmd.dispatch_rd))
      else $error("job load without a ready read");

   a_step_once: assert property (@(posedge clock) disable iff (reset)
      cmd.cpu_step |=> cmd.walk)
      else $error("walk did not follow the CPU update");

endmodule

// File: sv/fts_datapath.sv
// Ready FIFO, wait list, CPU job and result registers of the scheduler.
module fts_datapath
   import fts_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output status_type  status,
   input  logic        req_arrival_valid,
   input  logic [7:0]  req_arrival_pid,
   input  logic [9:0]  req_burst_ticks,
   input  logic [9:0]  req_io_request_tick,
   input  logic [9:0]  req_io_length_ticks,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_cpu_state,
   output logic [7:0]  rsp_running_pid,
   output logic [9:0]  rsp_running_left,
   output logic [4:0]  rsp_ready_level,
   output logic [4:0]  rsp_waiting_level,
   output logic        rsp_finished_valid,
   output logic        rsp_io_started_valid,
   output logic [7:0]  rsp_departed_pid,
   output logic        rsp_arrival_dropped,
   output logic        rsp_all_quiet
);

   // configuration
   logic [7:0] switch_ticks_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         switch_ticks_ff <= 8'd1;
      end else if (csr_wr_en) begin
         switch_ticks_ff <= csr_wr_data;
      end
   end

   // ready FIFO: circular buffer in RAM
   logic [PTR_W-1:0]  head_ff, head_in;
   logic [FILL_W-1:0] ready_fill_ff, ready_fill_in;
   logic [SUM_W-1:0]  tail_sum;
   logic [PTR_W-1:0]  tail;
   logic              ready_room;
   logic              rdy_wr_en;
   job_type           rdy_wr_data;
   job_type           rdy_rd_data;

   assign tail_sum   = SUM_W'(head_ff) + SUM_W'(ready_fill_ff);
   assign tail       = (tail_sum >= SUM_W'(JOB_SLOTS)) ?
                       PTR_W'(tail_sum - SUM_W'(JOB_SLOTS)) : PTR_W'(tail_sum);
   assign ready_room = (ready_fill_ff < FILL_W'(JOB_SLOTS));

   // wait list
   logic [FILL_W-1:0] wait_fill_ff, wait_fill_in;
   logic [FILL_W-1:0] rd_idx_ff, rd_idx_in;
   logic [FILL_W-1:0] keep_ff, keep_in;
   logic              proc_valid_ff;
   logic              walk_rd_en;
   logic              wt_wr_en;
   logic [PTR_W-1:0]  wt_wr_addr;
   waiter_type        wt_wr_data;
   waiter_type        wt_rd_data;
   logic [9:0]        cd_next;
   logic              rejoin;

   // CPU
   job_type           job_ff, job_in;
   logic [EXEC_W-1:0] exec_ff, exec_in;
   logic              busy_ff, busy_in;
   logic              switching_ff, switching_in;
   logic [7:0]        switch_left_ff, switch_left_in;
   logic              fin_ff, fin_in;
   logic              iost_ff, iost_in;
   logic [7:0]        dep_ff, dep_in;
   logic              dropped_ff, dropped_in;
   logic              done;
   logic              io_go;
   logic [9:0]        left_next;
   logic [EXEC_W-1:0] exec_next;

   assign done      = (job_ff.left <= 10'd1);
   assign left_next = (job_ff.left != 10'd0) ? job_ff.left - 10'd1 : 10'd0;
   assign exec_next = exec_ff + EXEC_W'(1);
   assign io_go     = (exec_next == EXEC_W'(job_ff.io_req)) && (job_ff.io_len != 10'd0) &&
                      (wait_fill_ff < FILL_W'(JOB_SLOTS));

   assign walk_rd_en = cmd.walk && (rd_idx_ff < wait_fill_ff);
   assign cd_next    = (wt_rd_data.countdown != 10'd0) ? wt_rd_data.countdown - 10'd1 : 10'd0;
   assign rejoin     = (cd_next == 10'd0) && ready_room;

   always_comb begin
      head_in        = head_ff;
      ready_fill_in  = ready_fill_ff;
      wait_fill_in   = wait_fill_ff;
      rd_idx_in      = rd_idx_ff;
      keep_in        = keep_ff;
      job_in         = job_ff;
      exec_in        = exec_ff;
      busy_in        = busy_ff;
      switching_in   = switching_ff;
      switch_left_in = switch_left_ff;
      fin_in         = fin_ff;
      iost_in        = iost_ff;
      dep_in         = dep_ff;
      dropped_in     = dropped_ff;
      rdy_wr_en      = 1'b0;
      rdy_wr_data    = '{pid: req_arrival_pid, left: req_burst_ticks,
                         io_req: req_io_request_tick, io_len: req_io_length_ticks};
      wt_wr_en       = 1'b0;
      wt_wr_addr     = keep_ff[PTR_W-1:0];
      wt_wr_data     = '{job: wt_rd_data.job, countdown: cd_next};

      if (cmd.accept) begin
         dropped_in = 1'b0;
         fin_in     = 1'b0;
         iost_in    = 1'b0;
         dep_in     = 8'd0;
         if (req_arrival_valid) begin
            if (ready_room) begin
               rdy_wr_en     = 1'b1;
               ready_fill_in = ready_fill_ff + FILL_W'(1);
            end else begin
               dropped_in = 1'b1;
            end
         end
      end

      if (cmd.load) begin
         job_in        = rdy_rd_data;
         exec_in       = '0;
         busy_in       = 1'b1;
         head_in       = (head_ff == PTR_W'(JOB_SLOTS - 1)) ? '0 : head_ff + PTR_W'(1);
         ready_fill_in = ready_fill_ff - FILL_W'(1);
      end

      if (cmd.cpu_step) begin
         rd_idx_in = '0;
         keep_in   = '0;
         if (switching_ff) begin
            if (switch_left_ff <= 8'd1) begin
               switch_left_in = 8'd0;
               switching_in   = 1'b0;
            end else begin
               switch_left_in = switch_left_ff - 8'd1;
            end
         end else if (busy_ff) begin
            job_in.left = left_next;
            exec_in     = exec_next;
            if (io_go || done) begin
               busy_in        = 1'b0;
               switching_in   = 1'b1;
               switch_left_in = switch_ticks_ff;
               dep_in         = job_ff.pid;
            end
            if (io_go) begin
               // a job does I/O at most once: clear io_len on the way out
               wt_wr_en       = 1'b1;
               wt_wr_addr     = wait_fill_ff[PTR_W-1:0];
               wt_wr_data     = '{job: '{pid: job_ff.pid, left: left_next,
                                         io_req: job_ff.io_req, io_len: 10'd0},
                                  countdown: job_ff.io_len};
               wait_fill_in   = wait_fill_ff + FILL_W'(1);
               iost_in        = 1'b1;
            end else if (done) begin
               fin_in = 1'b1;
            end
         end
      end

      if (cmd.walk) begin
         if (walk_rd_en) begin
            rd_idx_in = rd_idx_ff + FILL_W'(1);
         end
         if (proc_valid_ff) begin
            if (rejoin) begin
               rdy_wr_en     = 1'b1;
               rdy_wr_data   = wt_rd_data.job;
               ready_fill_in = ready_fill_ff + FILL_W'(1);
            end else begin
               wt_wr_en = 1'b1;
               keep_in  = keep_ff + FILL_W'(1);
            end
         end
         if (status.walk_done) begin
            wait_fill_in = keep_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff        <= '0;
         ready_fill_ff  <= '0;
         wait_fill_ff   <= '0;
         busy_ff        <= 1'b0;
         switching_ff   <= 1'b0;
         switch_left_ff <= 8'd0;
         proc_valid_ff  <= 1'b0;
      end else begin
         head_ff        <= head_in;
         ready_fill_ff  <= ready_fill_in;
         wait_fill_ff   <= wait_fill_in;
         busy_ff        <= busy_in;
         switching_ff   <= switching_in;
         switch_left_ff <= switch_left_in;
         proc_valid_ff  <= walk_rd_en;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff  <= rd_idx_in;
      keep_ff    <= keep_in;
      job_ff     <= job_in;
      exec_ff    <= exec_in;
      fin_ff     <= fin_in;
      iost_ff    <= iost_in;
      dep_ff     <= dep_in;
      dropped_ff <= dropped_in;
   end

   fts_ram #(
      .WIDTH ($bits(job_type)),
      .DEPTH (JOB_SLOTS)
   ) u_ready_ram (
      .clock   (clock),
      .wr_en   (rdy_wr_en),
      .wr_addr (tail),
      .wr_data (rdy_wr_data),
      .rd_en   (cmd.dispatch_rd),
      .rd_addr (head_ff),
      .rd_data (rdy_rd_data)
   );

   fts_ram #(
      .WIDTH ($bits(waiter_type)),
      .DEPTH (JOB_SLOTS)
   ) u_wait_ram (
      .clock   (clock),
      .wr_en   (wt_wr_en),
      .wr_addr (wt_wr_addr),
      .wr_data (wt_wr_data),
      .rd_en   (walk_rd_en),
      .rd_addr (rd_idx_ff[PTR_W-1:0]),
      .rd_data (wt_rd_data)
   );

   // result register
   logic       rsp_valid_ff;
   logic [1:0] out_state_ff;
   logic [7:0] out_pid_ff;
   logic [9:0] out_left_ff;
   logic [4:0] out_ready_ff;
   logic [4:0] out_wait_ff;
   logic       out_fin_ff;
   logic       out_iost_ff;
   logic [7:0] out_dep_ff;
   logic       out_drop_ff;
   logic       out_quiet_ff;

   assign status.dispatch_ok = !busy_ff && !switching_ff && (ready_fill_ff != '0);
   assign status.walk_done   = (rd_idx_ff >= wait_fill_ff) && !proc_valid_ff;
   assign status.out_free    = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_state_ff <= switching_ff ? CPU_SWITCHING : (busy_ff ? CPU_BUSY : CPU_IDLE);
         out_pid_ff   <= busy_ff ? job_ff.pid : 8'd0;
         out_left_ff  <= busy_ff ? job_ff.left : 10'd0;
         out_ready_ff <= 5'(ready_fill_ff);
         out_wait_ff  <= 5'(wait_fill_ff);
         out_fin_ff   <= fin_ff;
         out_iost_ff  <= iost_ff;
         out_dep_ff   <= dep_ff;
         out_drop_ff  <= dropped_ff;
         out_quiet_ff <= !busy_ff && !switching_ff && (ready_fill_ff == '0) &&
                         (wait_fill_ff == '0);
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_cpu_state        = out_state_ff;
   assign rsp_running_pid      = out_pid_ff;
   assign rsp_running_left     = out_left_ff;
   assign rsp_ready_level      = out_ready_ff;
   assign rsp_waiting_level    = out_wait_ff;
   assign rsp_finished_valid   = out_fin_ff;
   assign rsp_io_started_valid = out_iost_ff;
   assign rsp_departed_pid     = out_dep_ff;
   assign rsp_arrival_dropped  = out_drop_ff;
   assign rsp_all_quiet        = out_quiet_ff;

   a_fill_bounds: assert property (@(posedge clock) disable iff (reset)
      (ready_fill_ff <= FILL_W'(JOB_SLOTS)) && (wait_fill_ff <= FILL_W'(JOB_SLOTS)))
      else $error("fill count beyond capacity");

   a_cpu_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(busy_ff && switching_ff))
      else $error("CPU running and switching at once");

   a_compact_behind: assert property (@(posedge clock) disable iff (reset)
      cmd.walk |-> (keep_ff <= rd_idx_ff))
      else $error("wait list write overtook the read pointer");

   a_single_departure: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !(fin_ff && iost_ff))
      else $error("finish and I/O start on the same tick");

endmodule

// File: sv/fcfs_tick_scheduler_with_io.sv
// Top level of the FCFS tick scheduler with I/O waiting list.
// Each req_ item is one scheduler tick and may carry an arriving job
// (pid, burst, I/O request tick, I/O length). Each tick yields exactly one
// rsp_ item with the CPU state, running job, queue levels and departures.
// csr_wr_en/csr_wr_data set the context switch length; write only when idle.
// The time from acceptance to rsp_valid grows with the number of waiting
// jobs after the CPU update and with a dispatch. The wait list walk reads,
// counts down and compacts the wait RAM one entry per cycle.
// One tick is processed at a time; req_stall is high from acceptance until
// the result is loaded into the output register, so a new tick can be taken
// while the previous result still waits for the receiver.
// When rsp_stall is high the result holds; a following tick runs up to its
// result and then waits for the output register to free up.
// Reset (synchronous, active high) empties both queues, idles the CPU and
// sets the switch length to 1.
module fcfs_tick_scheduler_with_io
   import fts_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_arrival_valid,
   input  logic [7:0] req_arrival_pid,
   input  logic [9:0] req_burst_ticks,
   input  logic [9:0] req_io_request_tick,
   input  logic [9:0] req_io_length_ticks,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_cpu_state,
   output logic [7:0] rsp_running_pid,
   output logic [9:0] rsp_running_left,
   output logic [4:0] rsp_ready_level,
   output logic [4:0] rsp_waiting_level,
   output logic       rsp_finished_valid,
   output logic       rsp_io_started_valid,
   output logic [7:0] rsp_departed_pid,
   output logic       rsp_arrival_dropped,
   output logic       rsp_all_quiet
);

   cmd_type    cmd;
   status_type status;

   fts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   fts_datapath u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .req_arrival_valid    (req_arrival_valid),
      .req_arrival_pid      (req_arrival_pid),
      .req_burst_ticks      (req_burst_ticks),
      .req_io_request_tick  (req_io_request_tick),
      .req_io_length_ticks  (req_io_length_ticks),
      .csr_wr_en            (csr_wr_en),
      .csr_wr_data          (csr_wr_data),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_cpu_state        (rsp_cpu_state),
      .rsp_running_pid      (rsp_running_pid),
      .rsp_running_left     (rsp_running_left),
      .rsp_ready_level      (rsp_ready_level),
      .rsp_waiting_level    (rsp_waiting_level),
      .rsp_finished_valid   (rsp_finished_valid),
      .rsp_io_started_valid (rsp_io_started_valid),
      .rsp_departed_pid     (rsp_departed_pid),
      .rsp_arrival_dropped  (rsp_arrival_dropped),
      .rsp_all_quiet        (rsp_all_quiet)
   );

endmodule
